FILE: hw/rtl/tfd_pkg.sv
`timescale 1ns / 1ps
// tfd_pkg: shared types and constants of the texel format decoder
// no dependencies

package tfd_pkg;

  typedef enum logic [2:0] {
    FMT_RGB565 = 3'd0,
    FMT_RGB5A3 = 3'd1,
    FMT_I4     = 3'd2,
    FMT_IA4    = 3'd3,
    FMT_I8     = 3'd4,
    FMT_IA8    = 3'd5,
    FMT_RGBA8  = 3'd6,
    FMT_BAD    = 3'd7
  } format_e;

  localparam int unsigned WordW    = 16;
  localparam int unsigned ChanW    = 8;
  localparam logic [ChanW-1:0] Opaque = 8'hFF;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
    logic             last_of_run;
    logic             bad_format;
  } texel_t;

endpackage

FILE: hw/rtl/tfd_word_if.sv
`timescale 1ns / 1ps
// tfd_word_if: valid/ready channel carrying one raw storage word per item
// depends on tfd_pkg

interface tfd_word_if;
  logic                      valid;
  logic                      ready;
  logic [tfd_pkg::WordW-1:0] storage_word;

  modport source (output valid, output storage_word, input ready);
  modport sink (input valid, input storage_word, output ready);
endinterface

FILE: hw/rtl/tfd_texel_if.sv
`timescale 1ns / 1ps
// tfd_texel_if: valid/ready channel carrying one rgba8 texel per item
// depends on tfd_pkg

interface tfd_texel_if;
  logic                      valid;
  logic                      ready;
  logic [tfd_pkg::ChanW-1:0] red;
  logic [tfd_pkg::ChanW-1:0] green;
  logic [tfd_pkg::ChanW-1:0] blue;
  logic [tfd_pkg::ChanW-1:0] alpha;
  logic                      last_of_run;
  logic                      bad_format;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output last_of_run, output bad_format, input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                input last_of_run, input bad_format, output ready);
endinterface

FILE: hw/rtl/tfd_ram.sv
`timescale 1ns / 1ps
// tfd_ram: generic single-write, single-read synchronous ram, registered read
// no dependencies

module tfd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/texel_format_to_rgba8_decoder.sv
`timescale 1ns / 1ps
// texel_format_to_rgba8_decoder: raw texture words in, rgba8 texels out
// depends on tfd_pkg, tfd_word_if, tfd_texel_if, tfd_ram
// a texel passes the stage 1 register and then the output register before it is presented
// throughput: one item per cycle while the output accepts; an i4 item gives two texels on one port and holds the input
// rgba8 alpha-red words sit in a TILE_TEXELS-entry ram (16 by default) and are read back for the green-blue words
// reset: format rgb565, tile position zero, pipeline empty; ram contents undefined

module texel_format_to_rgba8_decoder #(
  parameter int unsigned TILE_TEXELS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  tfd_word_if.sink           in_i,
  tfd_texel_if.source        out_o
);

  localparam int unsigned IdxW = $clog2(TILE_TEXELS);
  localparam int unsigned PosW = IdxW + 1;

  tfd_pkg::format_e fmt_q;
  logic [PosW-1:0]  pos_q;

  logic                      s1_valid_q;
  logic                      s1_half_q;
  tfd_pkg::format_e          s1_fmt_q;
  logic [tfd_pkg::WordW-1:0] s1_word_q;

  logic            out_valid_q;
  tfd_pkg::texel_t out_q;
  tfd_pkg::texel_t texel;

  logic                      accept;
  logic                      ar_phase;
  logic                      out_free;
  logic                      emit;
  logic                      s1_last;
  logic                      s1_done;
  logic [tfd_pkg::WordW-1:0] ar_word;

  assign accept   = in_i.valid && in_i.ready;
  assign ar_phase = !pos_q[IdxW];
  assign out_free = !out_valid_q || out_o.ready;
  assign emit     = s1_valid_q && out_free;
  assign s1_last  = (s1_fmt_q != tfd_pkg::FMT_I4) || s1_half_q;
  assign s1_done  = emit && s1_last;
  assign in_i.ready = !s1_valid_q || s1_done;

  // alpha-red words go in during the first half of a tile, come out in the second
  tfd_ram #(
    .WIDTH(tfd_pkg::WordW),
    .DEPTH(TILE_TEXELS)
  ) u_ar_ram (
    .clk_i  (clk_i),
    .we_i   (accept && (fmt_q == tfd_pkg::FMT_RGBA8) && ar_phase),
    .waddr_i(pos_q[IdxW-1:0]),
    .wdata_i(in_i.storage_word),
    .re_i   (accept && (fmt_q == tfd_pkg::FMT_RGBA8) && !ar_phase),
    .raddr_i(pos_q[IdxW-1:0]),
    .rdata_o(ar_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= tfd_pkg::FMT_RGB565;
      pos_q <= '0;
    end else if (cfg_we_i) begin
      fmt_q <= tfd_pkg::format_e'(cfg_wdata_i);
      pos_q <= '0;
    end else if (accept && (fmt_q == tfd_pkg::FMT_RGBA8)) begin
      pos_q <= pos_q + PosW'(1);
    end
  end

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_half_q  <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= !((fmt_q == tfd_pkg::FMT_RGBA8) && ar_phase);
      s1_half_q  <= 1'b0;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
      s1_half_q  <= 1'b0;
    end else if (emit) begin
      s1_half_q  <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_fmt_q  <= fmt_q;
      s1_word_q <= in_i.storage_word;
    end
  end

  always_comb begin
    logic [3:0] nib;
    nib = s1_half_q ? s1_word_q[3:0] : s1_word_q[7:4];
    texel = '0;
    texel.alpha       = tfd_pkg::Opaque;
    texel.last_of_run = 1'b1;
    unique case (s1_fmt_q)
      tfd_pkg::FMT_RGB565: begin
        texel.red   = {s1_word_q[15:11], 3'b0};
        texel.green = {s1_word_q[10:5], 2'b0};
        texel.blue  = {s1_word_q[4:0], 3'b0};
      end
      tfd_pkg::FMT_RGB5A3: begin
        if (s1_word_q[15]) begin
          texel.red   = {s1_word_q[14:10], 3'b0};
          texel.green = {s1_word_q[9:5], 3'b0};
          texel.blue  = {s1_word_q[4:0], 3'b0};
        end else begin
          texel.red   = {s1_word_q[11:8], 4'b0};
          texel.green = {s1_word_q[7:4], 4'b0};
          texel.blue  = {s1_word_q[3:0], 4'b0};
          texel.alpha = {s1_word_q[14:12], 5'b0};
        end
      end
      tfd_pkg::FMT_I4: begin
        // high nibble first, low nibble closes the item
        texel.red         = {nib, 4'b0};
        texel.green       = {nib, 4'b0};
        texel.blue        = {nib, 4'b0};
        texel.last_of_run = s1_half_q;
      end
      tfd_pkg::FMT_IA4: begin
        texel.red   = {s1_word_q[3:0], 4'b0};
        texel.green = {s1_word_q[3:0], 4'b0};
        texel.blue  = {s1_word_q[3:0], 4'b0};
        texel.alpha = {s1_word_q[7:4], 4'b0};
      end
      tfd_pkg::FMT_I8: begin
        texel.red   = s1_word_q[7:0];
        texel.green = s1_word_q[7:0];
        texel.blue  = s1_word_q[7:0];
      end
      tfd_pkg::FMT_IA8: begin
        texel.red   = s1_word_q[7:0];
        texel.green = s1_word_q[7:0];
        texel.blue  = s1_word_q[7:0];
        texel.alpha = s1_word_q[15:8];
      end
      tfd_pkg::FMT_RGBA8: begin
        texel.alpha = ar_word[15:8];
        texel.red   = ar_word[7:0];
        texel.green = s1_word_q[15:8];
        texel.blue  = s1_word_q[7:0];
      end
      tfd_pkg::FMT_BAD: begin
        texel.alpha      = '0;
        texel.bad_format = 1'b1;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= texel;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.red         = out_q.red;
  assign out_o.green       = out_q.green;
  assign out_o.blue        = out_q.blue;
  assign out_o.alpha       = out_q.alpha;
  assign out_o.last_of_run = out_q.last_of_run;
  assign out_o.bad_format  = out_q.bad_format;

  // an alpha-red word leaves nothing in stage 1
  a_ar_no_texel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (fmt_q == tfd_pkg::FMT_RGBA8) && ar_phase) |=> !s1_valid_q)
    else $error("alpha-red word produced a texel");

  // only i4 items have a second texel
  a_half_i4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_half_q) |-> (s1_fmt_q == tfd_pkg::FMT_I4))
    else $error("second texel on a non-i4 item");

  // tile position moves only on rgba8 items or a format write
  a_pos_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!cfg_we_i && !(accept && (fmt_q == tfd_pkg::FMT_RGBA8))) |=> (pos_q == $past(pos_q)))
    else $error("tile position moved without an rgba8 item");

  // unsupported format gives a zero texel that closes its item
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.bad_format) |->
      (out_q.red == '0 && out_q.green == '0 && out_q.blue == '0 && out_q.alpha == '0 &&
       out_q.last_of_run))
    else $error("unsupported format texel not zero");

  // with the output side free, an i4 first texel is followed by its second in stage 1
  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_last && out_free) |=> (s1_valid_q && s1_half_q))
    else $error("i4 first texel not followed by second");

endmodule
